@@ rtl/core/ced_pkg.sv @@
// Shared types and constants of the control event detector.
`default_nettype none

package ced_pkg;

    // Fixed point levels, full scale is 16384
    localparam int STEER_W = 16;
    localparam int PEDAL_W = 15;
    localparam int BITS_W  = 8;
    localparam int TICK_W  = 64;
    localparam int IDX_W   = 16;
    localparam int NUM_W   = 16;
    localparam int KINDS   = 7;

    localparam logic signed [STEER_W-1:0] STEER_MAX   = 16'sd16384;
    localparam logic signed [STEER_W-1:0] STEER_MIN   = -16'sd16384;
    localparam logic signed [STEER_W-1:0] STEER_POS   = 16'sd3277;
    localparam logic signed [STEER_W-1:0] STEER_NEG   = -16'sd3277;
    localparam logic        [PEDAL_W-1:0] PEDAL_MAX   = 15'd16384;
    localparam logic        [PEDAL_W-1:0] PEDAL_HALF  = 15'd8192;

    // Configuration register indexes
    localparam logic [7:0] CFG_FIRST_TICK = 8'd0;
    localparam logic [7:0] CFG_CAPACITY   = 8'd1;
    localparam logic [7:0] CFG_UP_MASK    = 8'd2;
    localparam logic [7:0] CFG_DOWN_MASK  = 8'd3;
    localparam logic [7:0] CFG_RESET_MASK = 8'd4;

    // Event kinds, also the bit positions in the fired mask
    typedef enum logic [2:0] {
        KIND_THROTTLE  = 3'd0,
        KIND_BRAKE     = 3'd1,
        KIND_HANDBRAKE = 3'd2,
        KIND_SHIFT_UP  = 3'd3,
        KIND_SHIFT_DN  = 3'd4,
        KIND_RESET     = 3'd5,
        KIND_STEER     = 3'd6
    } t_kind;

    // One classified frame, handed from the front to the back
    typedef struct packed {
        logic        [TICK_W-1:0]  tick;
        logic        [IDX_W-1:0]   index;
        logic        [KINDS-1:0]   fire;
        logic        [PEDAL_W-1:0] throttle;
        logic        [PEDAL_W-1:0] brake;
        logic        [PEDAL_W-1:0] handbrake;
        logic signed [STEER_W-1:0] steer;
        logic        [NUM_W-1:0]   evnum;
    } t_frame_rec;

    // One event as it leaves the block
    typedef struct packed {
        logic        [TICK_W-1:0]  tick;
        logic        [IDX_W-1:0]   index;
        t_kind                     kind;
        logic signed [STEER_W-1:0] value;
        logic        [NUM_W-1:0]   number;
        logic                      last;
    } t_event;

endpackage

`default_nettype wire

@@ rtl/core/ced_front.sv @@
// Front end: configuration registers, frame classification and sequence state.
`default_nettype none

module ced_front #(
    parameter int MAX_FRAMES = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration write channel
    input  wire logic                  i_cfg_valid,
    input  wire logic [7:0]            i_cfg_index,
    input  wire logic [63:0]           i_cfg_data,
    // Frame request
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [71:0]           i_data,
    input  wire logic                  i_last,
    // Queue side
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output ced_pkg::t_frame_rec        o_rec
);
    import ced_pkg::*;

    localparam int CNT_W = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;

    logic [TICK_W-1:0]          r_first_tick;
    logic [NUM_W-1:0]           r_capacity;
    logic [BITS_W-1:0]          r_up_mask, r_down_mask, r_reset_mask;

    logic signed [STEER_W-1:0]  r_prev_steer, n_prev_steer;
    logic [PEDAL_W-1:0]         r_prev_thr, n_prev_thr;
    logic [PEDAL_W-1:0]         r_prev_brk, n_prev_brk;
    logic [PEDAL_W-1:0]         r_prev_hbk, n_prev_hbk;
    logic [CNT_W-1:0]           r_frame_cnt, n_frame_cnt;
    logic [NUM_W-1:0]           r_written, n_written;

    logic signed [STEER_W-1:0]  w_steer_raw, w_steer;
    logic [PEDAL_W-1:0]         w_thr, w_brk, w_hbk;
    logic [BITS_W-1:0]          w_bits;
    logic [KINDS-1:0]           w_fired, w_emit;
    logic [NUM_W:0]             w_room;
    logic [2:0]                 w_allow, w_count;
    logic                       w_accept;

    // Clamp a raw pedal reading to full scale
    function automatic logic [PEDAL_W-1:0] clamp_pedal(input logic [PEDAL_W-1:0] raw);
        clamp_pedal = (raw > PEDAL_MAX) ? PEDAL_MAX : raw;
    endfunction

    // Field extraction and clamping
    always_comb begin
        w_steer_raw = signed'(i_data[15:0]);
        if (w_steer_raw > STEER_MAX) begin
            w_steer = STEER_MAX;
        end else if (w_steer_raw < STEER_MIN) begin
            w_steer = STEER_MIN;
        end else begin
            w_steer = w_steer_raw;
        end
        w_thr  = clamp_pedal(i_data[30:16]);
        w_brk  = clamp_pedal(i_data[45:31]);
        w_hbk  = clamp_pedal(i_data[60:46]);
        w_bits = i_data[68:61];
    end

    // Event detection in the fixed kind order
    always_comb begin
        w_fired = '0;
        w_fired[KIND_THROTTLE]  = (r_prev_thr < PEDAL_HALF) != (w_thr < PEDAL_HALF);
        w_fired[KIND_BRAKE]     = (r_prev_brk < PEDAL_HALF) != (w_brk < PEDAL_HALF);
        w_fired[KIND_HANDBRAKE] = (r_prev_hbk < PEDAL_HALF) != (w_hbk < PEDAL_HALF);
        w_fired[KIND_SHIFT_UP]  = |(w_bits & r_up_mask);
        w_fired[KIND_SHIFT_DN]  = |(w_bits & r_down_mask);
        w_fired[KIND_RESET]     = |(w_bits & r_reset_mask);
        w_fired[KIND_STEER]     = ((r_prev_steer >= STEER_POS) && (w_steer <= STEER_NEG)) ||
                                  ((r_prev_steer <= STEER_NEG) && (w_steer >= STEER_POS));
    end

    // Capacity limit: keep only the first fired events that still fit
    always_comb begin
        if (r_written >= r_capacity) begin
            w_room = '0;
        end else begin
            w_room = {1'b0, r_capacity} - {1'b0, r_written};
        end
        w_allow = (w_room >= (NUM_W+1)'(KINDS)) ? 3'(KINDS) : w_room[2:0];
        w_emit  = '0;
        w_count = '0;
        for (int k = 0; k < KINDS; k++) begin
            if (w_fired[k] && (w_count < w_allow)) begin
                w_emit[k] = 1'b1;
                w_count   = w_count + 3'd1;
            end
        end
    end

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (|w_emit);

    // Record for the back end
    always_comb begin
        o_rec.tick      = r_first_tick + TICK_W'(r_frame_cnt);
        o_rec.index     = IDX_W'(r_frame_cnt);
        o_rec.fire      = w_emit;
        o_rec.throttle  = w_thr;
        o_rec.brake     = w_brk;
        o_rec.handbrake = w_hbk;
        o_rec.steer     = w_steer;
        o_rec.evnum     = r_written;
    end

    // Next sequence state; a last frame clears it
    always_comb begin
        n_prev_steer = r_prev_steer;
        n_prev_thr   = r_prev_thr;
        n_prev_brk   = r_prev_brk;
        n_prev_hbk   = r_prev_hbk;
        n_frame_cnt  = r_frame_cnt;
        n_written    = r_written;
        if (w_accept) begin
            if (i_last) begin
                n_prev_steer = '0;
                n_prev_thr   = '0;
                n_prev_brk   = '0;
                n_prev_hbk   = '0;
                n_frame_cnt  = '0;
                n_written    = '0;
            end else begin
                n_prev_steer = w_steer;
                n_prev_thr   = w_thr;
                n_prev_brk   = w_brk;
                n_prev_hbk   = w_hbk;
                n_frame_cnt  = (r_frame_cnt == CNT_W'(MAX_FRAMES - 1)) ? '0
                                                                     : r_frame_cnt + 1'b1;
                n_written    = r_written + NUM_W'(w_count);
            end
        end
    end

    // Sequence state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_steer <= '0;
            r_prev_thr   <= '0;
            r_prev_brk   <= '0;
            r_prev_hbk   <= '0;
            r_frame_cnt  <= '0;
            r_written    <= '0;
        end else begin
            r_prev_steer <= n_prev_steer;
            r_prev_thr   <= n_prev_thr;
            r_prev_brk   <= n_prev_brk;
            r_prev_hbk   <= n_prev_hbk;
            r_frame_cnt  <= n_frame_cnt;
            r_written    <= n_written;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_tick <= '0;
            r_capacity   <= 16'd65535;
            r_up_mask    <= 8'd1;
            r_down_mask  <= 8'd2;
            r_reset_mask <= 8'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIRST_TICK: r_first_tick <= i_cfg_data;
                CFG_CAPACITY:   r_capacity   <= i_cfg_data[NUM_W-1:0];
                CFG_UP_MASK:    r_up_mask    <= i_cfg_data[BITS_W-1:0];
                CFG_DOWN_MASK:  r_down_mask  <= i_cfg_data[BITS_W-1:0];
                CFG_RESET_MASK: r_reset_mask <= i_cfg_data[BITS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ced_queue.sv @@
// Short queue of classified frames between the front and the back end.
`default_nettype none

module ced_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire ced_pkg::t_frame_rec   i_rec,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_valid,
    output ced_pkg::t_frame_rec        o_rec
);
    import ced_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame_rec         r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ced_back.sv @@
// Back end: serialises the events of each frame into the output register.
`default_nettype none

module ced_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Queue side
    input  wire logic                  i_q_valid,
    input  wire ced_pkg::t_frame_rec   i_q_rec,
    output logic                       o_pop,
    // Event request
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output ced_pkg::t_event            o_event
);
    import ced_pkg::*;

    logic               r_busy, n_busy;
    t_frame_rec         r_rec, n_rec;
    logic [KINDS-1:0]   r_mask, n_mask;
    logic [NUM_W-1:0]   r_num, n_num;
    logic               r_out_valid, n_out_valid;
    t_event             r_out, n_out;

    logic               w_advance, w_emit, w_final;
    logic [KINDS-1:0]   w_onehot, w_rest;
    t_kind              w_kind;
    logic signed [STEER_W-1:0] w_value;

    // Lowest pending kind
    always_comb begin
        w_onehot = r_mask & (~r_mask + 1'b1);
        w_rest   = r_mask & ~w_onehot;
        w_kind   = KIND_THROTTLE;
        for (int k = KINDS - 1; k >= 0; k--) begin
            if (w_onehot[k]) begin
                w_kind = t_kind'(k);
            end
        end
    end

    // Value carried by the selected kind
    always_comb begin
        case (w_kind)
            KIND_THROTTLE:  w_value = signed'({1'b0, r_rec.throttle});
            KIND_BRAKE:     w_value = signed'({1'b0, r_rec.brake});
            KIND_HANDBRAKE: w_value = signed'({1'b0, r_rec.handbrake});
            KIND_STEER:     w_value = r_rec.steer;
            default:        w_value = '0;
        endcase
    end

    assign w_advance = !r_out_valid || i_ready;
    assign w_emit    = r_busy && w_advance;
    assign w_final   = (w_rest == '0);
    assign o_pop     = i_q_valid && (!r_busy || (w_emit && w_final));

    // Working frame register
    always_comb begin
        n_busy = r_busy;
        n_rec  = r_rec;
        n_mask = r_mask;
        n_num  = r_num;
        if (o_pop) begin
            n_busy = 1'b1;
            n_rec  = i_q_rec;
            n_mask = i_q_rec.fire;
            n_num  = i_q_rec.evnum;
        end else if (w_emit && w_final) begin
            n_busy = 1'b0;
        end else if (w_emit) begin
            n_mask = w_rest;
            n_num  = r_num + 1'b1;
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid  = 1'b1;
            n_out.tick   = r_rec.tick;
            n_out.index  = r_rec.index;
            n_out.kind   = w_kind;
            n_out.value  = w_value;
            n_out.number = r_num + 1'b1;
            n_out.last   = w_final;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec  <= n_rec;
        r_mask <= n_mask;
        r_num  <= n_num;
        r_out  <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_event = r_out;

endmodule

`default_nettype wire

@@ rtl/core/control_event_detector_top.sv @@
// Top level of the control event detector.
`default_nettype none

// The detector takes one control frame per request and emits its events, in kind order,
// one per cycle while the output is ready. The front end classifies a frame in the cycle
// it is accepted and takes a new frame every cycle while its four-entry frame queue has
// room; frames without events never enter the queue. The back end serialises the events
// of one frame at a time, so a frame with n events, one to seven, occupies it until all
// n are emitted; that serial emitter sets the sustained rate. An event passes through the
// frame queue, the working frame register and the output register on its way out.
// Configuration writes are always ready and take effect from the next frame.
module control_event_detector_top #(
    parameter int MAX_FRAMES  = 65536,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    // Frame input
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata: steer[15:0], throttle[30:16], brake[45:31], handbrake[60:46],
    //        oneshot_bits[68:61], zero fill[71:69]
    input  wire logic [71:0]  i_s_tdata,
    input  wire logic         i_s_tlast,   // last_frame
    // Event output
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata: event_tick[63:0], frame_index[79:64], event_kind[82:80],
    //        event_value[98:83], event_number[114:99], zero fill[119:115]
    output logic [119:0]      o_m_tdata,
    output logic              o_m_tlast    // last_of_run
);
    import ced_pkg::*;

    logic        w_push, w_q_full, w_pop, w_q_valid;
    t_frame_rec  w_front_rec, w_queue_rec;
    t_event      w_event;

    assign o_cfg_ready = 1'b1;

    ced_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_data      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_rec       (w_front_rec)
    );

    ced_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_rec   (w_queue_rec)
    );

    ced_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_rec   (w_queue_rec),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_event   (w_event)
    );

    // Output packing
    assign o_m_tdata = {5'd0, w_event.number, w_event.value, w_event.kind,
                        w_event.index, w_event.tick};
    assign o_m_tlast = w_event.last;

    // A frame is queued only when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("frame queued while queue full");

    // The back end only takes a frame that the queue holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("frame taken from empty queue");

    // A delivered event never carries an unused kind code or a zero event number
    a_event_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[82:80] != 3'd7) && (o_m_tdata[114:99] != 16'd0))
        else $error("malformed event");

endmodule

`default_nettype wire
